// ===== hdl/blcg_pkg.sv =====
// ----------------------------------------------------------------------------
// blcg_pkg
// Shared types and constants for the bounded lcg random generator core.
// ----------------------------------------------------------------------------
package blcg_pkg;

  // configuration port widths
  localparam int CFG_IDX_W  = 8;
  localparam int DATA_W     = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOW   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = CFG_IDX_W'(3);

  // generator and mixer constants
  localparam logic [DATA_W-1:0] LCG_MUL      = 32'd1664525;
  localparam logic [DATA_W-1:0] LCG_ADD      = 32'd1013904223;
  localparam logic [DATA_W-1:0] MIX_MUL_A    = 32'h7feb352d;
  localparam logic [DATA_W-1:0] MIX_MUL_B    = 32'h846ca68b;
  localparam logic [DATA_W-1:0] MIX_ZERO_SUB = 32'h6d2b79f5;

  // register reset values
  localparam logic [DATA_W-1:0] RST_LOW  = 32'd0;
  localparam logic [DATA_W-1:0] RST_HIGH = 32'd65535;

  // draw modes
  typedef enum logic [1:0] {
    MODE_RAW     = 2'd0,
    MODE_RANGED  = 2'd1,
    MODE_NONZERO = 2'd2,
    MODE_MIX     = 2'd3
  } mode_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LIM_DIV,
    ST_ADV_MUL,
    ST_ADV_ADD,
    ST_EVAL,
    ST_MIX_B,
    ST_MIX_END,
    ST_MOD_DIV,
    ST_RANGE_END,
    ST_FINISH
  } state_t;

endpackage

// ===== hdl/bounded_lcg_random_generator_core.sv =====
// ----------------------------------------------------------------------------
// bounded_lcg_random_generator_core
// 32-bit lcg with raw, ranged (rejection sampled), ranged nonzero and mixed
// draw modes, built around one shared multiplier and one restoring
// remainder step under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   handshake                     payload
//  -------   ---------------------------   -----------------------------------
//  draw      draw_valid / draw_ready       draw_request
//  result    result_valid / result_ready   draw_value, range_error, steps_used
//  cfg       cfg_valid / cfg_ready         cfg_index, cfg_data
//
//  A raw draw runs check, advance (multiply, add), evaluate and finish; a mixed
//  draw adds two mix steps. A ranged draw with a span below 2^32 first works out
//  the rejection limit once by bit-serial remainder; a kept advance then takes a
//  bit-serial remainder, a rejected one goes straight to the next advance. A full
//  span is drawn like a raw draw. draw_ready is high only in idle; a finished
//  item waits until the result register is free. rst is synchronous: sequencer
//  to idle, configuration, generator state and result_valid to reset values.
module bounded_lcg_random_generator_core (
  input  logic                             clk,
  input  logic                             rst,
  // draw channel
  input  logic                             draw_valid,
  output logic                             draw_ready,
  input  logic                             draw_request,
  // result channel
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [blcg_pkg::DATA_W-1:0]      draw_value,
  output logic                             range_error,
  output logic [blcg_pkg::DATA_W-1:0]      steps_used,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [blcg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blcg_pkg::DATA_W-1:0]      cfg_data
);

  import blcg_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  // configuration and generator state
  logic [DATA_W-1:0] range_low;
  logic [DATA_W-1:0] range_high;
  mode_t             draw_mode;
  logic [DATA_W-1:0] lcg_state;

  // sequencer and working registers
  state_t            state;
  state_t            state_next;
  logic [DATA_W-1:0] work;
  logic [DATA_W-1:0] steps;
  logic              err;
  logic [DATA_W-1:0] span;
  logic              span_full;
  logic [DATA_W-1:0] limit;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvd;
  logic [CNT_W-1:0]  cnt;

  // combinational helpers
  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [DATA_W-1:0] product;
  logic [DATA_W:0]   rem_shift;
  logic              rem_ge;
  logic [DATA_W-1:0] rem_new;
  logic [DATA_W:0]   span_calc;
  logic              low_above_high;
  logic              only_zero;
  logic              ranged_mode;
  logic [DATA_W-1:0] range_sum;
  logic [DATA_W-1:0] mix_final;
  logic [DATA_W-1:0] steps_inc;
  logic              out_free;
  logic              draw_accept;

  assign cfg_ready   = 1'b1;
  assign draw_ready  = (state == ST_IDLE);
  assign draw_accept = draw_valid && draw_ready;
  assign out_free    = !result_valid || result_ready;

  // range checks and span
  assign low_above_high = $signed(range_low) > $signed(range_high);
  assign only_zero      = (draw_mode == MODE_NONZERO) && (range_low == '0) &&
                          (range_high == '0);
  assign ranged_mode    = (draw_mode == MODE_RANGED) || (draw_mode == MODE_NONZERO);
  assign span_calc      = {range_high[DATA_W-1], range_high} -
                          {range_low[DATA_W-1], range_low} + (DATA_W+1)'(1);

  // shared multiplier, low word only
  always_comb begin
    unique case (state)
      ST_EVAL: begin
        mul_a = lcg_state ^ (lcg_state >> 16);
        mul_b = MIX_MUL_A;
      end
      ST_MIX_B: begin
        mul_a = work ^ (work >> 15);
        mul_b = MIX_MUL_B;
      end
      default: begin
        mul_a = lcg_state;
        mul_b = LCG_MUL;
      end
    endcase
  end
  assign product = mul_a * mul_b;

  // restoring remainder step, one dividend bit per cycle
  assign rem_shift = {rem, dvd[DATA_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, span};
  assign rem_new   = rem_ge ? DATA_W'(rem_shift - {1'b0, span}) : rem_shift[DATA_W-1:0];

  // final adds
  assign range_sum = range_low + rem;
  assign mix_final = ((work ^ (work >> 16)) == '0) ? MIX_ZERO_SUB : (work ^ (work >> 16));
  assign steps_inc = (steps == '1) ? steps : steps + DATA_W'(1);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (draw_accept && draw_request) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (ranged_mode && (low_above_high || only_zero)) begin
          state_next = ST_FINISH;
        end else if (ranged_mode && !span_calc[DATA_W]) begin
          state_next = ST_LIM_DIV;
        end else begin
          state_next = ST_ADV_MUL;
        end
      end
      ST_LIM_DIV: begin
        if (cnt == '0) state_next = ST_ADV_MUL;
      end
      ST_ADV_MUL: state_next = ST_ADV_ADD;
      ST_ADV_ADD: state_next = ST_EVAL;
      ST_EVAL: begin
        unique case (draw_mode)
          MODE_RAW: state_next = ST_FINISH;
          MODE_MIX: state_next = ST_MIX_B;
          MODE_RANGED, MODE_NONZERO: begin
            if (span_full) begin
              if (draw_mode == MODE_NONZERO && lcg_state == '0) begin
                state_next = ST_ADV_MUL;
              end else begin
                state_next = ST_FINISH;
              end
            end else if (lcg_state >= limit) begin
              state_next = ST_ADV_MUL;
            end else begin
              state_next = ST_MOD_DIV;
            end
          end
        endcase
      end
      ST_MIX_B:   state_next = ST_MIX_END;
      ST_MIX_END: state_next = ST_FINISH;
      ST_MOD_DIV: begin
        if (cnt == '0) state_next = ST_RANGE_END;
      end
      ST_RANGE_END: begin
        if (draw_mode == MODE_NONZERO && range_sum == '0) begin
          state_next = ST_ADV_MUL;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration registers and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= RST_LOW;
      range_high <= RST_HIGH;
      draw_mode  <= MODE_RANGED;
      lcg_state  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      priority case (cfg_index)
        REG_SEED: lcg_state  <= cfg_data;
        REG_LOW:  range_low  <= cfg_data;
        REG_HIGH: range_high <= cfg_data;
        REG_MODE: draw_mode  <= mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end else if (state == ST_ADV_ADD) begin
      lcg_state <= work + LCG_ADD;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        steps <= '0;
        err   <= 1'b0;
        work  <= '0;
      end
      ST_CHECK: begin
        span      <= span_calc[DATA_W-1:0];
        span_full <= span_calc[DATA_W];
        rem       <= '0;
        dvd       <= '1;
        cnt       <= '1;
        if (ranged_mode && (low_above_high || only_zero)) err <= 1'b1;
      end
      ST_LIM_DIV: begin
        rem <= rem_new;
        dvd <= dvd << 1;
        cnt <= cnt - CNT_W'(1);
        // limit is all ones minus the remainder
        if (cnt == '0) limit <= ~rem_new;
      end
      ST_ADV_MUL: work <= product;
      ST_ADV_ADD: steps <= steps_inc;
      ST_EVAL: begin
        rem <= '0;
        dvd <= lcg_state;
        cnt <= '1;
        if (draw_mode == MODE_MIX) begin
          work <= product;
        end else begin
          work <= lcg_state;
        end
      end
      ST_MIX_B:   work <= product;
      ST_MIX_END: work <= mix_final;
      ST_MOD_DIV: begin
        rem <= rem_new;
        dvd <= dvd << 1;
        cnt <= cnt - CNT_W'(1);
      end
      ST_RANGE_END: work <= range_sum;
      ST_FINISH: ;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      draw_value  <= work;
      range_error <= err;
      steps_used  <= steps;
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded lcg random generator core. A scoreboard
// class keeps its own copy of the registers and the generator state, works
// out the expected value, error flag and advance count for every accepted
// draw, and compares each returned result in order. Directed settings cover
// the range corner cases, then random settings and draws run with random
// gaps on the draw side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
  import blcg_pkg::*;

  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          DRAW_TARGET = 1600;
  localparam int          HOLD_CYCLES = 300;
  localparam int          SETTLE_CYCLES = 40;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

  typedef struct {
    bit [31:0] value;
    bit        err;
    bit [31:0] steps;
  } draw_result_t;

  // keeps the register copy, the generator state and the pending results
  class draw_scoreboard;
    bit [31:0]    seed_reg;
    bit [31:0]    low_reg;
    bit [31:0]    high_reg;
    mode_t        mode_reg;
    bit [31:0]    lcg;
    bit [31:0]    cur_steps;
    draw_result_t expected_q[$];
    int           errors;

    function new();
      seed_reg = '0;
      low_reg  = RST_LOW;
      high_reg = RST_HIGH;
      mode_reg = MODE_RANGED;
      lcg      = '0;
      errors   = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [31:0] data);
      case (idx)
        REG_SEED: begin
          seed_reg = data;
          lcg      = data;
        end
        REG_LOW:  low_reg  = data;
        REG_HIGH: high_reg = data;
        REG_MODE: mode_reg = mode_t'(data[1:0]);
        default: ;
      endcase
    endfunction

    // one generator advance, counting steps with saturation
    function bit [31:0] step_lcg();
      lcg = lcg * LCG_MUL + LCG_ADD;
      if (cur_steps != 32'hffff_ffff) cur_steps++;
      return lcg;
    endfunction

    // one rejection-sampled draw in [low, high]; caller checks low <= high
    function bit [31:0] bounded_draw();
      longint    span;
      bit [31:0] span32;
      bit [31:0] limit;
      bit [31:0] v;
      span = longint'($signed(high_reg)) - longint'($signed(low_reg)) + 1;
      if (span > 64'hffff_ffff) return step_lcg();
      span32 = span[31:0];
      limit  = 32'hffff_ffff - (32'hffff_ffff % span32);
      v = step_lcg();
      while (v >= limit) v = step_lcg();
      return low_reg + (v % span32);
    endfunction

    function void note_draw(bit req);
      bit [31:0] v;
      bit        err;
      if (!req) return;
      cur_steps = '0;
      v   = '0;
      err = 1'b0;
      if (mode_reg == MODE_RAW) begin
        v = step_lcg();
      end else if (mode_reg == MODE_MIX) begin
        v = step_lcg();
        v ^= v >> 16;
        v = v * MIX_MUL_A;
        v ^= v >> 15;
        v = v * MIX_MUL_B;
        v ^= v >> 16;
        if (v == '0) v = MIX_ZERO_SUB;
      end else if ($signed(low_reg) > $signed(high_reg)) begin
        err = 1'b1;
      end else if (mode_reg == MODE_NONZERO && low_reg == '0 && high_reg == '0) begin
        err = 1'b1;
      end else begin
        v = bounded_draw();
        if (mode_reg == MODE_NONZERO) begin
          while (v == '0) v = bounded_draw();
        end
      end
      expected_q.push_back('{v, err, cur_steps});
    endfunction

    function void check_result(bit [31:0] value, bit err, bit [31:0] steps);
      draw_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result with no draw pending: draw_value %h", value);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (exp_res.value !== value) begin
        $error("draw_value: expected %h, got %h", exp_res.value, value);
        errors++;
      end
      if (exp_res.err !== err) begin
        $error("range_error: expected %0d, got %0d", exp_res.err, err);
        errors++;
      end
      if (exp_res.steps !== steps) begin
        $error("steps_used: expected %0d, got %0d", exp_res.steps, steps);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 draw_valid;
  logic                 draw_ready;
  logic                 draw_request;
  logic                 result_valid;
  logic                 result_ready;
  logic [DATA_W-1:0]    draw_value;
  logic                 range_error;
  logic [DATA_W-1:0]    steps_used;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  draw_scoreboard sb = new();
  bit             no_idle = 1'b0;
  bit             hold_request = 1'b0;
  int             draws_sent = 0;
  int             cycle_count = 0;

  bounded_lcg_random_generator_core dut (
    .clk          (clk),
    .rst          (rst),
    .draw_valid   (draw_valid),
    .draw_ready   (draw_ready),
    .draw_request (draw_request),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .draw_value   (draw_value),
    .range_error  (range_error),
    .steps_used   (steps_used),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none in a no-idle stretch
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // handshake monitor: register writes, results, then accepted draws
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (result_valid && result_ready) sb.check_result(draw_value, range_error, steps_used);
      if (draw_valid && draw_ready) sb.note_draw(draw_request);
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          result_ready <= 1'b0;
          stall_left--;
        end else begin
          result_ready <= 1'b1;
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  // offer one draw item and hold it until accepted
  task automatic send_draw(bit req);
    @(negedge clk);
    draw_valid   <= 1'b1;
    draw_request <= req;
    do @(posedge clk); while (!draw_ready);
  endtask

  // drop valid for a pause set by n; zero keeps the next item back to back
  task automatic pause_draw(int n);
    if (n > 0) begin
      @(negedge clk);
      draw_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic cfg_put(bit [CFG_IDX_W-1:0] idx, bit [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // wait for all results and a quiet block, then write a new setting
  task automatic apply_setting(bit [31:0] low, bit [31:0] high, mode_t mode,
                               bit load_seed, bit [31:0] seed);
    pause_draw(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (load_seed) cfg_put(REG_SEED, seed);
    cfg_put(REG_LOW, low);
    cfg_put(REG_HIGH, high);
    cfg_put(REG_MODE, {30'd0, mode});
    // out-of-list index now and then, must be ignored
    if ($urandom_range(0, 3) == 0) cfg_put(CFG_IDX_W'($urandom_range(4, 255)), $urandom());
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // a run of draws, a share of them with the request bit clear
  task automatic run_draws(int n, int zero_pct);
    bit req;
    repeat (n) begin
      req = ($urandom_range(0, 99) >= zero_pct);
      send_draw(req);
      if (req) draws_sent++;
      pause_draw(pick_gap());
    end
  endtask

  // stimulus
  initial begin
    bit [31:0] inv;
    bit [31:0] zero_seed;
    longint    lo_s;
    longint    hi_s;
    bit [31:0] lo;
    bit [31:0] hi;
    int        phase;

    rst          = 1'b1;
    draw_valid   = 1'b0;
    draw_request = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // seed whose first advance lands on zero: -add times inverse of mul
    inv = LCG_MUL;
    repeat (5) inv = inv * (32'd2 - LCG_MUL * inv);
    zero_seed = (32'd0 - LCG_ADD) * inv;

    // reset setting, and one draw with the request bit clear
    run_draws(2, 0);
    send_draw(1'b0);
    pause_draw(1);
    // raw mode from the top seed and from the seed that gives zero
    apply_setting(RST_LOW, RST_HIGH, MODE_RAW, 1'b1, 32'hffff_ffff);
    run_draws(2, 0);
    apply_setting(RST_LOW, RST_HIGH, MODE_RAW, 1'b1, zero_seed);
    run_draws(1, 0);
    // mixed mode where the mix comes out zero and gets substituted
    apply_setting(RST_LOW, RST_HIGH, MODE_MIX, 1'b1, zero_seed);
    run_draws(2, 0);
    // low above high in both ranged modes
    apply_setting(32'd5, 32'd4, MODE_RANGED, 1'b0, '0);
    run_draws(1, 0);
    apply_setting(32'd5, 32'd4, MODE_NONZERO, 1'b0, '0);
    run_draws(1, 0);
    // only zero possible: error in nonzero mode, plain zero in ranged mode
    apply_setting('0, '0, MODE_NONZERO, 1'b0, '0);
    run_draws(1, 0);
    apply_setting('0, '0, MODE_RANGED, 1'b0, '0);
    run_draws(1, 0);
    // full span returns the raw state
    apply_setting(INT_MIN, INT_MAX, MODE_RANGED, 1'b1, 32'h1234_5678);
    run_draws(2, 0);
    apply_setting(INT_MIN, INT_MAX, MODE_NONZERO, 1'b0, '0);
    run_draws(1, 0);
    // span just above half: about half the advances rejected
    apply_setting(32'hffff_ffff, INT_MAX, MODE_RANGED, 1'b0, '0);
    run_draws(2, 0);
    // zero inside a tiny span gets redrawn
    apply_setting(32'hffff_ffff, 32'd1, MODE_NONZERO, 1'b0, '0);
    run_draws(2, 0);
    apply_setting(INT_MIN, INT_MIN, MODE_RANGED, 1'b0, '0);
    run_draws(1, 0);
    apply_setting(INT_MAX, INT_MAX, MODE_NONZERO, 1'b0, '0);
    run_draws(1, 0);

    // random settings and draws
    phase = 0;
    while (draws_sent < DRAW_TARGET) begin
      case ($urandom_range(0, 5))
        0: begin
          lo_s = longint'($signed($urandom()));
          hi_s = lo_s + $urandom_range(0, 15);
          if (hi_s > longint'($signed(INT_MAX))) hi_s = longint'($signed(INT_MAX));
          lo = lo_s[31:0];
          hi = hi_s[31:0];
        end
        1: begin
          lo = $urandom();
          hi = $urandom();
        end
        2: begin
          lo = INT_MIN;
          hi = INT_MAX;
        end
        3: begin
          if ($urandom_range(0, 1) == 0) begin
            lo = 32'hffff_ffff;
            hi = INT_MAX;
          end else begin
            lo = INT_MIN;
            hi = '0;
          end
        end
        4: begin
          lo = 32'd0 - $urandom_range(0, 3);
          hi = $urandom_range(0, 3);
        end
        default: begin
          hi = $urandom();
          lo = ($signed(hi) == $signed(INT_MAX)) ? INT_MIN : hi + $urandom_range(1, 1000);
          if ($signed(lo) <= $signed(hi)) lo = INT_MAX;
          if (hi == INT_MAX) hi = INT_MIN;
        end
      endcase
      apply_setting(lo, hi, mode_t'($urandom_range(0, 3)), $urandom_range(0, 1), $urandom());
      no_idle = ($urandom_range(0, 4) == 0);
      // long result hold-off while draws keep coming
      if (phase == 3) hold_request = 1'b1;
      run_draws($urandom_range(20, 60), 5);
      phase++;
    end

    // drain and let the block go quiet
    pause_draw(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
